FILE: rtl/arp_pkg.sv
// Shared types and constants for the ARP cache resolver.
`default_nettype none

package arp_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // Field widths
  localparam int IP_W  = 32;
  localparam int MAC_W = 48;
  localparam int OP_W  = 16;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 1'd1;

  // ARP opcode for a request
  localparam logic [OP_W-1:0] OP_REQUEST = 16'd1;

  // Broadcast hardware address
  localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_W{1'b1}};

  // Result action codes
  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_REPLY   = 2'd1,
    ACT_FORWARD = 2'd2,
    ACT_REQUEST = 2'd3
  } action_e;

endpackage

`default_nettype wire

FILE: rtl/arp_cache_resolver.sv
// Top level of the ARP cache resolver: table memory, scan sequencer and result register.
`default_nettype none

// The table lives in a synchronous memory of TABLE_ENTRIES (IP, MAC) rows with
// registered read data, filled in order behind a fill count, so reset
// leaves it empty at once with no clearing pass. Each item is scanned against
// the filled rows one row per cycle through the single memory read port: the
// item is accepted, the filled rows are read and compared, and it finishes,
// with the scan ending early at the first matching row; on an empty table it
// goes straight from accept to finish. A received packet whose sender is not
// yet present inserts it in the finish state unless the table is full; a
// resolve only reads. The result sits in an output register, so the next item
// is taken while the previous result waits. The own_mac register is accepted
// on the configuration port and then ignored, and shows in no result field.
module arp_cache_resolver (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // configuration write channel
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [arp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [arp_pkg::MAC_W-1:0]     cfg_data_i,
  // input item channel
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire                          cmd_i,
  input  wire [arp_pkg::OP_W-1:0]      opcode_i,
  input  wire [arp_pkg::IP_W-1:0]      src_ip_i,
  input  wire [arp_pkg::MAC_W-1:0]     src_mac_i,
  input  wire [arp_pkg::IP_W-1:0]      tgt_ip_i,
  input  wire [arp_pkg::IP_W-1:0]      dst_ip_i,
  // result channel
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [1:0]                   action_o,
  output logic [arp_pkg::MAC_W-1:0]    out_mac_o,
  output logic [arp_pkg::IP_W-1:0]     out_ip_o,
  output logic                         insert_dropped_o
);

  import arp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // Control state
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  ptr_q, ptr_d;
  logic [IDX_W-1:0]  cmp_idx_q;
  logic              cmp_vld_q, cmp_vld_d;
  logic              hit_q, hit_d;
  logic              out_valid_q, out_valid_d;
  logic [IP_W-1:0]   own_ip_q;

  // Item payload
  logic              cmd_q;
  logic              reply_q;
  logic [IP_W-1:0]   key_q;
  logic [MAC_W-1:0]  smac_q;
  logic [MAC_W-1:0]  hit_mac_q;

  // Table memory and its registered read data
  logic [IP_W-1:0]   mem_ip  [TABLE_ENTRIES];
  logic [MAC_W-1:0]  mem_mac [TABLE_ENTRIES];
  logic [IP_W-1:0]   rd_ip_q;
  logic [MAC_W-1:0]  rd_mac_q;

  // Result register
  action_e           res_action_q, res_action;
  logic [MAC_W-1:0]  res_mac_q, res_mac;
  logic [IP_W-1:0]   res_ip_q, res_ip;
  logic              res_drop_q, res_drop;

  logic              in_acc, out_load, do_write;
  logic              match, cmp_last, ptr_last, tbl_full, zero_hit, found;
  logic [CNT_W-1:0]  last_cnt;

  // Handshakes
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);

  // Scan compare against the row read last cycle
  assign last_cnt = count_q - CNT_W'(1);
  assign match    = cmp_vld_q && (rd_ip_q == key_q);
  assign cmp_last = (CNT_W'(cmp_idx_q) == last_cnt);
  assign ptr_last = (CNT_W'(ptr_q) == last_cnt);
  assign tbl_full = (count_q == CNT_W'(TABLE_ENTRIES));
  // A key of zero matches the first empty row
  assign zero_hit = (key_q == '0) && !tbl_full;
  assign found    = hit_q || zero_hit;

  // Sequencer next state
  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    cmp_vld_d   = 1'b0;
    hit_d       = hit_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ptr_d = '0;
          hit_d = 1'b0;
          state_d = (count_q == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmp_vld_d = 1'b1;
        ptr_d = ptr_last ? ptr_q : ptr_q + IDX_W'(1);
        if (match) begin
          hit_d = 1'b1;
          cmp_vld_d = 1'b0;
          state_d = ST_FINISH;
        end else if (cmp_vld_q && cmp_last) begin
          cmp_vld_d = 1'b0;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
          if (do_write) begin
            count_d = count_q + CNT_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result of the finished item
  always_comb begin
    res_action = ACT_NONE;
    res_mac    = '0;
    res_ip     = '0;
    res_drop   = 1'b0;
    do_write   = 1'b0;
    if (cmd_q) begin
      res_ip = key_q;
      if (found) begin
        res_action = ACT_FORWARD;
        res_mac    = hit_q ? hit_mac_q : '0;
      end else begin
        res_action = ACT_REQUEST;
        res_mac    = BCAST_MAC;
      end
    end else begin
      if (!found) begin
        res_drop = tbl_full;
        do_write = !tbl_full;
      end
      if (reply_q) begin
        res_action = ACT_REPLY;
        res_mac    = smac_q;
        res_ip     = key_q;
      end
    end
  end

  // Hold control state and the output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ptr_q       <= '0;
      cmp_idx_q   <= '0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      own_ip_q    <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      cmp_idx_q   <= ptr_q;
      cmp_vld_q   <= cmp_vld_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o && (cfg_idx_i == CFG_OWN_IP)) begin
        own_ip_q <= cfg_data_i[IP_W-1:0];
      end
    end
  end

  // Capture the item and the matching row
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q   <= cmd_i;
      key_q   <= cmd_i ? dst_ip_i : src_ip_i;
      smac_q  <= src_mac_i;
      reply_q <= (tgt_ip_i == own_ip_q) && (opcode_i == OP_REQUEST);
    end
    if (match) begin
      hit_mac_q <= rd_mac_q;
    end
    if (out_load) begin
      res_action_q <= res_action;
      res_mac_q    <= res_mac;
      res_ip_q     <= res_ip;
      res_drop_q   <= res_drop;
    end
  end

  // Table memory: write a new sender at the fill count, read one row per cycle
  always_ff @(posedge clk_i) begin
    if (out_load && do_write) begin
      mem_ip[count_q[IDX_W-1:0]]  <= key_q;
      mem_mac[count_q[IDX_W-1:0]] <= smac_q;
    end
    rd_ip_q  <= mem_ip[ptr_q];
    rd_mac_q <= mem_mac[ptr_q];
  end

  // Drive the result channel
  assign out_valid_o      = out_valid_q;
  assign action_o         = res_action_q;
  assign out_mac_o        = res_mac_q;
  assign out_ip_o         = res_ip_q;
  assign insert_dropped_o = res_drop_q;

endmodule

`default_nettype wire

FILE: rtl/arp_chk.sv
// Port-level checker for the ARP cache resolver and its bind.
`default_nettype none

module arp_chk (
  input wire                       clk_i,
  input wire                       rst_ni,
  input wire                       out_valid_o,
  input wire                       out_stall_i,
  input wire [1:0]                 action_o,
  input wire [arp_pkg::MAC_W-1:0]  out_mac_o,
  input wire [arp_pkg::IP_W-1:0]   out_ip_o,
  input wire                       insert_dropped_o
);

  import arp_pkg::*;

  // A broadcast request always carries the all-ones address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (action_o == ACT_REQUEST)) |-> (out_mac_o == BCAST_MAC))
    else $error("request beat without broadcast MAC");

  // No action means empty address fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (action_o == ACT_NONE)) |-> ((out_mac_o == '0) && (out_ip_o == '0)))
    else $error("no-action beat with nonzero fields");

  // A dropped insert only comes from a received packet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && insert_dropped_o) |->
      ((action_o == ACT_NONE) || (action_o == ACT_REPLY)))
    else $error("dropped insert flagged on a resolve beat");

  // A stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(action_o) && $stable(out_mac_o) && $stable(out_ip_o)))
    else $error("stalled result beat changed");

endmodule

bind arp_cache_resolver arp_chk u_arp_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .action_o         (action_o),
  .out_mac_o        (out_mac_o),
  .out_ip_o         (out_ip_o),
  .insert_dropped_o (insert_dropped_o)
);

`default_nettype wire

FILE: tb/arp_cache_resolver_test.sv
// Self-checking testbench for the ARP cache resolver: table inserts, replies and resolves.
`timescale 1ns / 1ps

module arp_cache_resolver_test;
  import arp_pkg::*;

  // Received ARP packet or outgoing resolve
  localparam logic CMD_RX      = 1'b0;
  localparam logic CMD_RESOLVE = 1'b1;
  localparam logic [OP_W-1:0] OP_REPLY = 16'd2;

  // Margin for the last item to finish after the queue drains
  localparam int SETTLE     = 24;
  localparam int LONG_HOLD  = 400;
  localparam int POOL_SIZE  = 64;
  localparam int MAX_REPORT = 10;

  typedef struct packed {
    logic             cmd;
    logic [OP_W-1:0]  opcode;
    logic [IP_W-1:0]  src_ip;
    logic [MAC_W-1:0] src_mac;
    logic [IP_W-1:0]  tgt_ip;
    logic [IP_W-1:0]  dst_ip;
  } arp_in_t;

  typedef struct packed {
    action_e          action;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;
    logic             dropped;
  } arp_result_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [MAC_W-1:0]     cfg_data  = '0;
  wire                  cfg_ready;

  logic             in_valid = 1'b0;
  logic             cmd      = 1'b0;
  logic [OP_W-1:0]  opcode   = '0;
  logic [IP_W-1:0]  src_ip   = '0;
  logic [MAC_W-1:0] src_mac  = '0;
  logic [IP_W-1:0]  tgt_ip   = '0;
  logic [IP_W-1:0]  dst_ip   = '0;
  wire              in_stall;

  logic             out_stall = 1'b0;
  wire              out_valid;
  wire [1:0]        action;
  wire [MAC_W-1:0]  out_mac;
  wire [IP_W-1:0]   out_ip;
  wire              insert_dropped;

  // Shadow of the block: own address and the IP/MAC table
  logic [IP_W-1:0]  own_ip_q = '0;
  logic [IP_W-1:0]  cache_ip  [TABLE_ENTRIES];
  logic [MAC_W-1:0] cache_mac [TABLE_ENTRIES];
  logic [IP_W-1:0]  ip_pool   [POOL_SIZE];

  arp_result_t pending_results[$];
  int  mismatches    = 0;
  bit  tx_idle_en    = 1'b0;
  bit  rx_idle_en    = 1'b0;
  bit  long_hold_req = 1'b0;

  arp_cache_resolver uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .cmd_i           (cmd),
    .opcode_i        (opcode),
    .src_ip_i        (src_ip),
    .src_mac_i       (src_mac),
    .tgt_ip_i        (tgt_ip),
    .dst_ip_i        (dst_ip),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .action_o        (action),
    .out_mac_o       (out_mac),
    .out_ip_o        (out_ip),
    .insert_dropped_o(insert_dropped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    return MAC_W'({$urandom, $urandom});
  endfunction

  // Compute the result of one item and advance the shadow table
  function automatic arp_result_t predict_arp(arp_in_t it);
    arp_result_t r;
    bit          done;
    int          k;
    r.action  = ACT_NONE;
    r.mac     = '0;
    r.ip      = '0;
    r.dropped = 1'b0;
    done      = 1'b0;
    if (it.cmd == CMD_RX) begin
      // Store sender in first empty row unless already present
      for (k = 0; k < TABLE_ENTRIES; k++) begin
        if (!done && cache_ip[k] == it.src_ip) begin
          done = 1'b1;
        end else if (!done && cache_ip[k] == '0) begin
          cache_ip[k]  = it.src_ip;
          cache_mac[k] = it.src_mac;
          done = 1'b1;
        end
      end
      r.dropped = !done;
      if (it.tgt_ip == own_ip_q && it.opcode == OP_REQUEST) begin
        r.action = ACT_REPLY;
        r.mac    = it.src_mac;
        r.ip     = it.src_ip;
      end
    end else begin
      // First matching row wins; an IP of zero matches an empty row
      r.action = ACT_REQUEST;
      r.mac    = BCAST_MAC;
      r.ip     = it.dst_ip;
      for (k = 0; k < TABLE_ENTRIES; k++) begin
        if (!done && cache_ip[k] == it.dst_ip) begin
          r.action = ACT_FORWARD;
          r.mac    = cache_mac[k];
          done = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic arp_in_t rx_item(logic [OP_W-1:0] op, logic [IP_W-1:0] sip,
                                      logic [MAC_W-1:0] smac, logic [IP_W-1:0] tip);
    arp_in_t it;
    it.cmd     = CMD_RX;
    it.opcode  = op;
    it.src_ip  = sip;
    it.src_mac = smac;
    it.tgt_ip  = tip;
    it.dst_ip  = $urandom;
    return it;
  endfunction

  function automatic arp_in_t resolve_item(logic [IP_W-1:0] dip);
    arp_in_t it;
    it.cmd     = CMD_RESOLVE;
    it.opcode  = OP_W'($urandom);
    it.src_ip  = $urandom;
    it.src_mac = rand_mac();
    it.tgt_ip  = $urandom;
    it.dst_ip  = dip;
    return it;
  endfunction

  // Random item drawn mostly from a pool of addresses so that hits and
  // known senders are common; fresh_pct controls new addresses
  function automatic arp_in_t random_arp(int pool_span, int fresh_pct);
    arp_in_t it;
    int      pick;
    logic [IP_W-1:0] sip;
    logic [OP_W-1:0] op;
    logic [IP_W-1:0] tip;
    it = resolve_item($urandom);
    if ($urandom_range(0, 1) == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < fresh_pct)
        sip = $urandom;
      else if (pick < fresh_pct + 8)
        sip = '0;
      else
        sip = ip_pool[$urandom_range(0, pool_span - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 45)      op = OP_REQUEST;
      else if (pick < 80) op = OP_REPLY;
      else                op = OP_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 50)      tip = own_ip_q;
      else if (pick < 70) tip = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
      else                tip = $urandom;
      it = rx_item(op, sip, rand_mac(), tip);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      it.dst_ip = ip_pool[$urandom_range(0, pool_span - 1)];
      else if (pick < 65) it.dst_ip = '0;
    end
    return it;
  endfunction

  // Offer one beat and predict its result once accepted
  task automatic send_arp(arp_in_t it);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= it.cmd;
    opcode   <= it.opcode;
    src_ip   <= it.src_ip;
    src_mac  <= it.src_mac;
    tgt_ip   <= it.tgt_ip;
    dst_ip   <= it.dst_ip;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_arp(it));
  endtask

  task automatic run_random(int count, int pool_span, int fresh_pct);
    repeat (count) send_arp(random_arp(pool_span, fresh_pct));
  endtask

  // Drop valid and let every outstanding result drain
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [MAC_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_idx   <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_OWN_IP) own_ip_q = data[IP_W-1:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Upper data bits are junk on an own_ip write; the block must mask them
  task automatic set_own_address(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
    logic [MAC_W-IP_W-1:0] junk;
    junk = (MAC_W-IP_W)'($urandom);
    quiesce();
    write_cfg(CFG_OWN_IP, {junk, ip});
    write_cfg(CFG_OWN_MAC, mac);
  endtask

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORT)
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
  endtask

  // Receiver stall: random bursts, plus one long hold on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        long_hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted result beat with the oldest prediction
  always @(posedge clk) begin : check_results
    arp_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result action", '0, 64'(action));
      end else begin
        want = pending_results.pop_front();
        if (want.action != action)
          report_mismatch("action", 64'(want.action), 64'(action));
        if (want.mac != out_mac)
          report_mismatch("out_mac", 64'(want.mac), 64'(out_mac));
        if (want.ip != out_ip)
          report_mismatch("out_ip", 64'(want.ip), 64'(out_ip));
        if (want.dropped != insert_dropped)
          report_mismatch("insert_dropped", 64'(want.dropped), 64'(insert_dropped));
      end
    end
  end

  localparam logic [IP_W-1:0]  HOST_A   = 32'h0A00_01F0;
  localparam logic [IP_W-1:0]  HOST_B   = 32'hAC10_02F1;
  localparam logic [MAC_W-1:0] HOST_MAC = 48'h02_11_22_33_44_55;

  // Resolves against an empty table: zero hits an empty row, others miss
  task automatic test_empty_table();
    set_own_address(32'hC0A8_0064, rand_mac());
    send_arp(resolve_item('0));
    send_arp(resolve_item('1));
  endtask

  // Reply only for a request aimed at our IP; every new nonzero sender gets stored
  task automatic test_received_packets();
    send_arp(rx_item(OP_REQUEST, HOST_A, HOST_MAC, own_ip_q));
    send_arp(rx_item(OP_REPLY, HOST_B, rand_mac(), own_ip_q));
    send_arp(rx_item('1, '1, '1, '1));
    send_arp(rx_item('0, '0, rand_mac(), '0));
    send_arp(rx_item(OP_REQUEST, 32'h0000_0000, '1, own_ip_q));
    send_arp(rx_item('1, HOST_A, rand_mac(), own_ip_q));
  endtask

  // Known sender keeps its first MAC; zero still finds an empty row
  task automatic test_resolve_hits();
    send_arp(resolve_item(HOST_A));
    send_arp(resolve_item(HOST_B));
    send_arp(resolve_item('1));
    send_arp(resolve_item('0));
    send_arp(rx_item(OP_REQUEST, HOST_A, '0, own_ip_q));
  endtask

  task automatic test_random_partial_table();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    run_random(300, 12, 0);
  endtask

  // Fill every row, then drops, a reply while full and a zero resolve miss
  task automatic test_table_full();
    bit room;
    int n;
    int k;
    room = 1'b1;
    for (n = 0; room; n++) begin
      room = 1'b0;
      for (k = 0; k < TABLE_ENTRIES; k++)
        if (cache_ip[k] == '0) room = 1'b1;
      if (room) send_arp(rx_item(OP_REPLY, 32'hE000_0000 + n, rand_mac(), '0));
    end
    send_arp(rx_item(OP_REQUEST, 32'hE100_0001, rand_mac(), own_ip_q));
    send_arp(rx_item(OP_REPLY, '0, rand_mac(), own_ip_q));
    send_arp(rx_item(OP_REPLY, HOST_A, rand_mac(), own_ip_q));
    send_arp(resolve_item('0));
    send_arp(resolve_item(32'hE100_0001));
  endtask

  // Hold the result side off long enough that the input stalls
  task automatic test_backpressure();
    set_own_address(ip_pool[3], '1);
    long_hold_req = 1'b1;
    run_random(300, 40, 15);
  endtask

  // Sweep own address across its extremes
  task automatic test_own_address_sweep();
    set_own_address('0, '0);
    run_random(120, 40, 15);
    set_own_address('1, '1);
    run_random(120, 40, 15);
    set_own_address($urandom, rand_mac());
    run_random(120, 40, 15);
  endtask

  task automatic test_streaming();
    set_own_address(HOST_B, rand_mac());
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_random(250, 40, 15);
  endtask

  initial begin
    int k;
    logic [31:0] r;
    for (k = 0; k < TABLE_ENTRIES; k++) begin
      cache_ip[k]  = '0;
      cache_mac[k] = '0;
    end
    // Pool addresses are nonzero and distinct through their low byte
    for (k = 0; k < POOL_SIZE; k++) begin
      r = $urandom;
      ip_pool[k] = {r[31:8], k[7:0] + 8'd1};
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_received_packets();
    test_resolve_hits();
    test_random_partial_table();
    test_table_full();
    test_backpressure();
    test_own_address_sweep();
    test_streaming();

    // Drain with a bound, then allow stray beats to show up
    in_valid <= 1'b0;
    for (k = 0; k < 4000 && pending_results.size() != 0; k++) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (pending_results.size() != 0)
      $display("%0d results never arrived", pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0)
      $display("arp_cache_resolver verification clean");
    else
      $display("arp_cache_resolver verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("arp_cache_resolver verification failed");
    $finish;
  end

endmodule
